### rtl/core/slmc_pkg.sv
// ----------------------------------------------------------------------------
// slmc_pkg
// Shared types and constants for the servo link mode controller
// ----------------------------------------------------------------------------
package slmc_pkg;

	localparam int unsigned OFS_W   = 9;
	localparam int unsigned STICK_W = 10;
	localparam int unsigned THR_W   = 11;
	localparam int unsigned BTN_W   = 8;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned PULSE_W = 11;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;

	// mode codes as seen on the result stream
	localparam logic [MODE_W-1:0] MODE_WAIT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NORM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CAL  = 2'd2;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_OFS_X_START = 3'd0;
	localparam logic [2:0] REG_OFS_Y_START = 3'd1;
	localparam logic [2:0] REG_LINK_TMO    = 3'd2;
	localparam logic [2:0] REG_ZERO_HOLD   = 3'd3;
	localparam logic [2:0] REG_REFRESH     = 3'd4;

	localparam logic [MS_W-1:0]   LINK_TMO_RST     = 16'd500;
	localparam logic [MS_W-1:0]   ZERO_HOLD_RST    = 16'd5000;
	localparam logic [MS_W-1:0]   REFRESH_RST      = 16'd100;
	localparam logic [TIME_W-1:0] LAST_PKT_RST     = 32'h0000_8000;
	localparam logic [TIME_W-1:0] REFRESH_TIME_RST = 32'h8000_0000;

	localparam int OFS_STEP  = 8;
	localparam int OFS_LIMIT = 160;
	localparam int PULSE_MIN = 1000;
	localparam int PULSE_MAX = 2000;

	typedef struct packed {
		logic signed [OFS_W-1:0] ofs_x_start;
		logic signed [OFS_W-1:0] ofs_y_start;
		logic [MS_W-1:0]         link_timeout_ms;
		logic [MS_W-1:0]         zero_hold_ms;
		logic [MS_W-1:0]         refresh_ms;
	} cfg_t;

	typedef struct packed {
		logic                      packet_valid;
		logic signed [STICK_W-1:0] stick_x;
		logic signed [STICK_W-1:0] stick_y;
		logic signed [THR_W-1:0]   throttle;
		logic [BTN_W-1:0]          buttons;
		logic [TIME_W-1:0]         now_ms;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic                    drive_update;
		logic [PULSE_W-1:0]      servo_x_us;
		logic [PULSE_W-1:0]      servo_y_us;
		logic signed [THR_W-1:0] throttle_out;
		logic signed [OFS_W-1:0] offset_x;
		logic signed [OFS_W-1:0] offset_y;
		logic                    save_offsets;
	} result_t;

endpackage

### rtl/core/slmc_regs.sv
// ----------------------------------------------------------------------------
// slmc_regs
// Configuration register file behind the APB-style port
// ----------------------------------------------------------------------------
module slmc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [slmc_pkg::ADDR_W-1:0]  paddr,
	input  logic [slmc_pkg::DATA_W-1:0]  pwdata,
	output logic [slmc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output slmc_pkg::cfg_t               cfg,
	output logic                         ofs_load
);
	import slmc_pkg::*;

	cfg_t       cfg_q;
	logic       ofs_load_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ofs_x_start     <= '0;
			cfg_q.ofs_y_start     <= '0;
			cfg_q.link_timeout_ms <= LINK_TMO_RST;
			cfg_q.zero_hold_ms    <= ZERO_HOLD_RST;
			cfg_q.refresh_ms      <= REFRESH_RST;
			ofs_load_q            <= 1'b0;
		end else begin
			ofs_load_q <= 1'b0;
			if (wr) begin
				case (idx)
					REG_OFS_X_START: begin
						cfg_q.ofs_x_start <= pwdata[OFS_W-1:0];
						ofs_load_q        <= 1'b1;
					end
					REG_OFS_Y_START: begin
						cfg_q.ofs_y_start <= pwdata[OFS_W-1:0];
						ofs_load_q        <= 1'b1;
					end
					REG_LINK_TMO:  cfg_q.link_timeout_ms <= pwdata[MS_W-1:0];
					REG_ZERO_HOLD: cfg_q.zero_hold_ms    <= pwdata[MS_W-1:0];
					REG_REFRESH:   cfg_q.refresh_ms      <= pwdata[MS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_OFS_X_START: prdata = {{(DATA_W-OFS_W){1'b0}}, cfg_q.ofs_x_start};
			REG_OFS_Y_START: prdata = {{(DATA_W-OFS_W){1'b0}}, cfg_q.ofs_y_start};
			REG_LINK_TMO:    prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.link_timeout_ms};
			REG_ZERO_HOLD:   prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.zero_hold_ms};
			REG_REFRESH:     prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.refresh_ms};
			default:         prdata = '0;
		endcase
	end

	assign cfg      = cfg_q;
	assign ofs_load = ofs_load_q;

endmodule

### rtl/core/slmc_engine.sv
// ----------------------------------------------------------------------------
// slmc_engine
// Mode state, latched commands, offsets and the per-tick step logic
// ----------------------------------------------------------------------------
module slmc_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  slmc_pkg::item_t   item,
	input  slmc_pkg::cfg_t    cfg,
	input  logic              ofs_load,
	output slmc_pkg::result_t result
);
	import slmc_pkg::*;

	typedef enum logic [2:0] {
		ST_WAIT = 3'b001,
		ST_NORM = 3'b010,
		ST_CAL  = 3'b100
	} mode_state_t;

	localparam logic signed [OFS_W:0]   OFS_LIM_S  = (OFS_W+1)'(OFS_LIMIT);
	localparam logic signed [OFS_W:0]   OFS_STEP_S = (OFS_W+1)'(OFS_STEP);
	localparam logic signed [12:0]      PMIN_S     = 13'(PULSE_MIN);
	localparam logic signed [12:0]      PMAX_S     = 13'(PULSE_MAX);

	function automatic logic signed [OFS_W-1:0] trim(input logic signed [OFS_W-1:0] ofs,
			input logic up);
		logic signed [OFS_W:0] v;
		v = up ? ($signed({ofs[OFS_W-1], ofs}) + OFS_STEP_S)
		       : ($signed({ofs[OFS_W-1], ofs}) - OFS_STEP_S);
		if (v > OFS_LIM_S)
			v = OFS_LIM_S;
		else if (v < -OFS_LIM_S)
			v = -OFS_LIM_S;
		return v[OFS_W-1:0];
	endfunction

	// (v+512)*1000/1023 + 1000 + ofs, clamped; /1023 by shift plus one correction
	function automatic logic [PULSE_W-1:0] pulse(input logic signed [STICK_W-1:0] v,
			input logic signed [OFS_W-1:0] ofs);
		logic [STICK_W-1:0]  n;
		logic [19:0]         p;
		logic [9:0]          q0;
		logic [10:0]         r;
		logic [10:0]         q;
		logic signed [12:0]  s;
		n  = {~v[STICK_W-1], v[STICK_W-2:0]};
		p  = 20'(n) * 20'd1000;
		q0 = p[19:10];
		r  = {1'b0, p[9:0]} + {1'b0, q0};
		q  = {1'b0, q0} + ((r >= 11'd1023) ? 11'd1 : 11'd0);
		s  = $signed({2'b00, q}) + PMIN_S + 13'($signed(ofs));
		if (s >= PMAX_S)
			s = PMAX_S;
		else if (s <= PMIN_S)
			s = PMIN_S;
		return s[PULSE_W-1:0];
	endfunction

	mode_state_t               mode_q, mode_n;
	logic signed [STICK_W-1:0] lx_q, ly_q, lx_n, ly_n;
	logic signed [THR_W-1:0]   lt_q, lt_n;
	logic [BTN_W-1:0]          lb_q, lb_n;
	logic [TIME_W-1:0]         last_pkt_q, last_pkt_n;
	logic [TIME_W-1:0]         refresh_t_q, refresh_t_n;
	logic                      zero_seen_q, zero_seen_n;
	logic [TIME_W-1:0]         zero_t_q, zero_t_n;
	logic [BTN_W-1:0]          hist0_q, hist1_q, hist0_n, hist1_n;
	logic signed [OFS_W-1:0]   ofs_x_q, ofs_y_q, ofs_x_n, ofs_y_n;
	logic signed [OFS_W-1:0]   sav_x_q, sav_y_q, sav_x_n, sav_y_n;
	logic signed [OFS_W-1:0]   ld_x, ld_y;
	logic                      pkt, drive, save, do_btn, do_refresh;
	logic                      link_lost, refresh_due, hold_done;
	logic [BTN_W-1:0]          pressed;
	logic [MODE_W-1:0]         mode_code;

	// start offsets fall back to zero when either lies outside the trim range
	always_comb begin
		ld_x = cfg.ofs_x_start;
		ld_y = cfg.ofs_y_start;
		if ($signed({cfg.ofs_x_start[OFS_W-1], cfg.ofs_x_start}) > OFS_LIM_S ||
		    $signed({cfg.ofs_x_start[OFS_W-1], cfg.ofs_x_start}) < -OFS_LIM_S ||
		    $signed({cfg.ofs_y_start[OFS_W-1], cfg.ofs_y_start}) > OFS_LIM_S ||
		    $signed({cfg.ofs_y_start[OFS_W-1], cfg.ofs_y_start}) < -OFS_LIM_S) begin
			ld_x = '0;
			ld_y = '0;
		end
	end

	always_comb begin
		pkt         = item.packet_valid;
		lx_n        = pkt ? item.stick_x  : lx_q;
		ly_n        = pkt ? item.stick_y  : ly_q;
		lt_n        = pkt ? item.throttle : lt_q;
		lb_n        = pkt ? item.buttons  : lb_q;
		last_pkt_n  = pkt ? item.now_ms   : last_pkt_q;
		link_lost   = (item.now_ms - last_pkt_n) > {16'b0, cfg.link_timeout_ms};
		refresh_due = (item.now_ms - refresh_t_q) > {16'b0, cfg.refresh_ms};
		hold_done   = (item.now_ms - zero_t_q) > {16'b0, cfg.zero_hold_ms};

		mode_n      = mode_q;
		refresh_t_n = refresh_t_q;
		zero_seen_n = zero_seen_q;
		zero_t_n    = zero_t_q;
		hist0_n     = hist0_q;
		hist1_n     = hist1_q;
		ofs_x_n     = ofs_x_q;
		ofs_y_n     = ofs_y_q;
		sav_x_n     = sav_x_q;
		sav_y_n     = sav_y_q;
		drive       = 1'b0;
		save        = 1'b0;
		do_btn      = 1'b0;
		do_refresh  = 1'b0;

		case (mode_q)
			ST_NORM: begin
				if (!pkt) begin
					if (link_lost) begin
						do_refresh = 1'b1;
						mode_n     = ST_WAIT;
					end
				end else begin
					drive = 1'b1;
					if (lt_n == '0) begin
						if (!zero_seen_q) begin
							zero_seen_n = 1'b1;
							zero_t_n    = item.now_ms;
						end else if (hold_done) begin
							zero_seen_n = 1'b0;
							mode_n      = ST_CAL;
							do_btn      = 1'b1;
						end
					end else begin
						zero_seen_n = 1'b0;
					end
				end
			end
			ST_CAL: begin
				if (pkt) begin
					drive = 1'b1;
					if (lt_n != '0) begin
						// leaving calibration: flag a save if the trim moved
						if (ofs_x_q != sav_x_q || ofs_y_q != sav_y_q) begin
							save    = 1'b1;
							sav_x_n = ofs_x_q;
							sav_y_n = ofs_y_q;
						end
						zero_seen_n = 1'b0;
						mode_n      = ST_NORM;
					end else begin
						do_btn = 1'b1;
					end
				end else if (link_lost) begin
					do_refresh = 1'b1;
					mode_n     = ST_WAIT;
				end
			end
			default: begin
				mode_n = ST_WAIT;
				if (pkt && lt_n == '0) begin
					mode_n = ST_CAL;
					drive  = 1'b1;
					do_btn = 1'b1;
				end else begin
					do_refresh = 1'b1;
				end
			end
		endcase

		// rising edge over three calibration samples, first bit wins
		pressed = lb_n & ~hist0_q & ~hist1_q;
		if (do_btn) begin
			hist1_n = hist0_q;
			hist0_n = lb_n;
			if (pressed[0])
				ofs_y_n = trim(ofs_y_q, 1'b1);
			else if (pressed[1])
				ofs_y_n = trim(ofs_y_q, 1'b0);
			else if (pressed[2])
				ofs_x_n = trim(ofs_x_q, 1'b0);
			else if (pressed[3])
				ofs_x_n = trim(ofs_x_q, 1'b1);
		end

		if (do_refresh && refresh_due) begin
			drive       = 1'b1;
			refresh_t_n = item.now_ms;
			lx_n        = '0;
			ly_n        = '0;
			lt_n        = '0;
			lb_n        = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ST_WAIT;
			lx_q        <= '0;
			ly_q        <= '0;
			lt_q        <= '0;
			lb_q        <= '0;
			last_pkt_q  <= LAST_PKT_RST;
			refresh_t_q <= REFRESH_TIME_RST;
			zero_seen_q <= 1'b0;
			zero_t_q    <= '0;
			hist0_q     <= '0;
			hist1_q     <= '0;
			ofs_x_q     <= '0;
			ofs_y_q     <= '0;
			sav_x_q     <= '0;
			sav_y_q     <= '0;
		end else if (fire) begin
			mode_q      <= mode_n;
			lx_q        <= lx_n;
			ly_q        <= ly_n;
			lt_q        <= lt_n;
			lb_q        <= lb_n;
			last_pkt_q  <= last_pkt_n;
			refresh_t_q <= refresh_t_n;
			zero_seen_q <= zero_seen_n;
			zero_t_q    <= zero_t_n;
			hist0_q     <= hist0_n;
			hist1_q     <= hist1_n;
			ofs_x_q     <= ofs_x_n;
			ofs_y_q     <= ofs_y_n;
			sav_x_q     <= sav_x_n;
			sav_y_q     <= sav_y_n;
		end else if (ofs_load) begin
			ofs_x_q <= ld_x;
			ofs_y_q <= ld_y;
			sav_x_q <= ld_x;
			sav_y_q <= ld_y;
		end
	end

	always_comb begin
		case (mode_n)
			ST_NORM: mode_code = MODE_NORM;
			ST_CAL:  mode_code = MODE_CAL;
			default: mode_code = MODE_WAIT;
		endcase
	end

	always_comb begin
		result.mode         = mode_code;
		result.drive_update = drive;
		result.servo_x_us   = drive ? pulse(lx_n, ofs_x_n) : '0;
		result.servo_y_us   = drive ? pulse(ly_n, ofs_y_n) : '0;
		result.throttle_out = drive ? lt_n : '0;
		result.offset_x     = ofs_x_n;
		result.offset_y     = ofs_y_n;
		result.save_offsets = save;
	end

endmodule

### rtl/core/servo_link_mode_controller_top.sv
// Path: an accepted tick is held in the input register, runs through the step logic and
// is held in the result register; a held result stalls the input once both are full.
// Throughput: one tick per cycle while m_axis takes results; the mode and offset state
// closes through the step logic between the input register and the result register.
// Reset: arst_n clears all state but the tick and result data at once: waiting mode, zero
// offsets, default timeouts (500, 5000, 100 ms); no clearing pass.
// ----------------------------------------------------------------------------
// servo_link_mode_controller_top
// Servo link mode controller: tick stream in, drive result stream out
// ----------------------------------------------------------------------------
module servo_link_mode_controller_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// stick_x[9:0], stick_y[19:10], throttle[30:20], buttons[38:31], now_ms[70:39]
	input  logic [71:0]                 s_axis_tdata,
	// packet_valid[0]
	input  logic                        s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// servo_x_us[10:0], servo_y_us[21:11], throttle_out[32:22], offset_x[41:33],
	// offset_y[50:42], save_offsets[51]
	output logic [55:0]                 m_axis_tdata,
	// mode[1:0], drive_update[2]
	output logic [2:0]                  m_axis_tuser,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [slmc_pkg::ADDR_W-1:0] paddr,
	input  logic [slmc_pkg::DATA_W-1:0] pwdata,
	output logic [slmc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import slmc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    adv;
	logic    fire;
	cfg_t    cfg;
	logic    ofs_load;

	assign adv           = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.packet_valid <= s_axis_tuser;
			item_s1.stick_x      <= s_axis_tdata[9:0];
			item_s1.stick_y      <= s_axis_tdata[19:10];
			item_s1.throttle     <= s_axis_tdata[30:20];
			item_s1.buttons      <= s_axis_tdata[38:31];
			item_s1.now_ms       <= s_axis_tdata[70:39];
		end
		if (fire)
			res_q <= res;
	end

	slmc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.ofs_load (ofs_load)
	);

	slmc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cfg      (cfg),
		.ofs_load (ofs_load),
		.result   (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {res_q.drive_update, res_q.mode};
	assign m_axis_tdata  = {4'b0, res_q.save_offsets, res_q.offset_y, res_q.offset_x,
		res_q.throttle_out, res_q.servo_y_us, res_q.servo_x_us};

endmodule

### rtl/core/slmc_checker.sv
// ----------------------------------------------------------------------------
// slmc_port_checks
// Port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
module slmc_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);
	import slmc_pkg::*;

	// no drive means servo and throttle fields read zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[32:0] == '0))
		else $error("undriven result carries servo or throttle data");

	// a driven pulse stays inside the servo window
	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |->
		(m_axis_tdata[10:0] >= 11'd1000 && m_axis_tdata[10:0] <= 11'd2000 &&
		 m_axis_tdata[21:11] >= 11'd1000 && m_axis_tdata[21:11] <= 11'd2000))
		else $error("servo pulse outside 1000..2000 us");

	// a save is only flagged on the driven transfer that returns to normal
	a_save_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[51]) |->
		(m_axis_tuser[1:0] == MODE_NORM && m_axis_tuser[2]))
		else $error("save flagged outside a calibration exit");

	// mode code never takes the unused value
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tuser[1:0] == MODE_WAIT || m_axis_tuser[1:0] == MODE_NORM ||
		 m_axis_tuser[1:0] == MODE_CAL))
		else $error("unused mode code on result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind servo_link_mode_controller_top slmc_port_checks u_slmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### bench/slmc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slmc_tb_pkg
// Button bit positions shared by the stimulus and the checker
// ----------------------------------------------------------------------------
package slmc_tb_pkg;

	localparam int BTN_Y_UP   = 0;
	localparam int BTN_Y_DOWN = 1;
	localparam int BTN_X_DOWN = 2;
	localparam int BTN_X_UP   = 3;

endpackage

### bench/slmc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slmc_checker
// Watches the tick stream, the register port and the result stream of the
// servo link mode controller, predicts every result and compares it field by
// field with what the block returns
// ----------------------------------------------------------------------------
module slmc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [71:0]                 s_axis_tdata,
	input  logic                        s_axis_tuser,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [55:0]                 m_axis_tdata,
	input  logic [2:0]                  m_axis_tuser,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [slmc_pkg::ADDR_W-1:0] paddr,
	input  logic [slmc_pkg::DATA_W-1:0] pwdata,
	output int                          results_due,
	output int                          mismatches
);
	import slmc_pkg::*;
	import slmc_tb_pkg::*;

	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;

	logic signed [OFS_W-1:0] start_ofs [2];
	logic [MS_W-1:0]         link_tmo;
	logic [MS_W-1:0]         hold_lim;
	logic [MS_W-1:0]         refr_lim;

	logic [MODE_W-1:0] mode_now;
	int                lat_x;
	int                lat_y;
	int                lat_thr;
	logic [BTN_W-1:0]  lat_btn;
	logic [TIME_W-1:0] last_pkt_t;
	logic [TIME_W-1:0] refr_t;
	logic [TIME_W-1:0] zero_t;
	bit                zero_armed;
	logic [BTN_W-1:0]  btn_hist [2];
	int                ofs_now [2];
	int                ofs_saved [2];

	result_t servo_results_due [$];
	int      fails = 0;

	initial begin
		results_due = 0;
		mismatches  = 0;
	end

	// true when the time elapsed since a mark, modulo 2^32, exceeds the limit
	function automatic bit overdue(logic [TIME_W-1:0] now, logic [TIME_W-1:0] mark,
			logic [MS_W-1:0] lim);
		logic [TIME_W-1:0] span;
		span = now - mark;
		return span > {{(TIME_W-MS_W){1'b0}}, lim};
	endfunction

	function automatic logic [PULSE_W-1:0] pulse_us(int v, int ofs);
		int p;
		p = ((v + 512) * 1000) / 1023 + PULSE_MIN + ofs;
		if (p >= PULSE_MAX) p = PULSE_MAX;
		else if (p <= PULSE_MIN) p = PULSE_MIN;
		return p[PULSE_W-1:0];
	endfunction

	task automatic reload_offsets();
		int a;
		int b;
		a = int'(start_ofs[AXIS_X]);
		b = int'(start_ofs[AXIS_Y]);
		// an out-of-range start value throws both away
		if (a > OFS_LIMIT || a < -OFS_LIMIT || b > OFS_LIMIT || b < -OFS_LIMIT) begin
			a = 0;
			b = 0;
		end
		ofs_now[AXIS_X]   = a;
		ofs_now[AXIS_Y]   = b;
		ofs_saved[AXIS_X] = a;
		ofs_saved[AXIS_Y] = b;
	endtask

	task automatic clear_model();
		start_ofs[AXIS_X] = '0;
		start_ofs[AXIS_Y] = '0;
		link_tmo   = LINK_TMO_RST;
		hold_lim   = ZERO_HOLD_RST;
		refr_lim   = REFRESH_RST;
		mode_now   = MODE_WAIT;
		lat_x      = 0;
		lat_y      = 0;
		lat_thr    = 0;
		lat_btn    = '0;
		last_pkt_t = LAST_PKT_RST;
		refr_t     = REFRESH_TIME_RST;
		zero_armed = 1'b0;
		zero_t     = '0;
		btn_hist[0] = '0;
		btn_hist[1] = '0;
		reload_offsets();
	endtask

	task automatic apply_register(logic [2:0] idx, logic [DATA_W-1:0] val);
		case (idx)
		REG_OFS_X_START: begin
			start_ofs[AXIS_X] = val[OFS_W-1:0];
			reload_offsets();
		end
		REG_OFS_Y_START: begin
			start_ofs[AXIS_Y] = val[OFS_W-1:0];
			reload_offsets();
		end
		REG_LINK_TMO: link_tmo = val[MS_W-1:0];
		REG_ZERO_HOLD: hold_lim = val[MS_W-1:0];
		REG_REFRESH: refr_lim = val[MS_W-1:0];
		default: ;
		endcase
	endtask

	task automatic nudge(int axis, int delta);
		int v;
		v = ofs_now[axis] + delta;
		if (v > OFS_LIMIT) v = OFS_LIMIT;
		if (v < -OFS_LIMIT) v = -OFS_LIMIT;
		ofs_now[axis] = v;
	endtask

	// a press needs the bit clear in both earlier calibration packets
	task automatic scan_buttons();
		logic [BTN_W-1:0] fresh;
		fresh = lat_btn & ~btn_hist[0] & ~btn_hist[1];
		btn_hist[1] = btn_hist[0];
		btn_hist[0] = lat_btn;
		if (fresh[BTN_Y_UP]) nudge(AXIS_Y, OFS_STEP);
		else if (fresh[BTN_Y_DOWN]) nudge(AXIS_Y, -OFS_STEP);
		else if (fresh[BTN_X_DOWN]) nudge(AXIS_X, -OFS_STEP);
		else if (fresh[BTN_X_UP]) nudge(AXIS_X, OFS_STEP);
	endtask

	task automatic zero_refresh(logic [TIME_W-1:0] now, output bit drove);
		drove = 1'b0;
		if (overdue(now, refr_t, refr_lim)) begin
			refr_t  = now;
			lat_x   = 0;
			lat_y   = 0;
			lat_thr = 0;
			lat_btn = '0;
			drove   = 1'b1;
		end
	endtask

	task automatic predict_servo_tick(item_t tick, output result_t r);
		bit drive;
		bit save;
		drive = 1'b0;
		save  = 1'b0;
		if (tick.packet_valid) begin
			last_pkt_t = tick.now_ms;
			lat_x      = int'($signed(tick.stick_x));
			lat_y      = int'($signed(tick.stick_y));
			lat_thr    = int'($signed(tick.throttle));
			lat_btn    = tick.buttons;
		end

		case (mode_now)
		MODE_NORM: begin
			if (!tick.packet_valid) begin
				if (overdue(tick.now_ms, last_pkt_t, link_tmo)) begin
					zero_refresh(tick.now_ms, drive);
					mode_now = MODE_WAIT;
				end
			end else begin
				drive = 1'b1;
				if (lat_thr == 0) begin
					if (!zero_armed) begin
						zero_armed = 1'b1;
						zero_t     = tick.now_ms;
					end else if (overdue(tick.now_ms, zero_t, hold_lim)) begin
						zero_armed = 1'b0;
						mode_now   = MODE_CAL;
						scan_buttons();
					end
				end else begin
					zero_armed = 1'b0;
				end
			end
		end
		MODE_CAL: begin
			if (tick.packet_valid) begin
				drive = 1'b1;
				if (lat_thr != 0) begin
					// leaving calibration: buttons are not looked at on this tick
					if (ofs_now[AXIS_X] != ofs_saved[AXIS_X] ||
							ofs_now[AXIS_Y] != ofs_saved[AXIS_Y]) begin
						save = 1'b1;
						ofs_saved[AXIS_X] = ofs_now[AXIS_X];
						ofs_saved[AXIS_Y] = ofs_now[AXIS_Y];
					end
					zero_armed = 1'b0;
					mode_now   = MODE_NORM;
				end else begin
					scan_buttons();
				end
			end else if (overdue(tick.now_ms, last_pkt_t, link_tmo)) begin
				zero_refresh(tick.now_ms, drive);
				mode_now = MODE_WAIT;
			end
		end
		default: begin
			mode_now = MODE_WAIT;
			if (tick.packet_valid && lat_thr == 0) begin
				mode_now = MODE_CAL;
				drive    = 1'b1;
				scan_buttons();
			end else begin
				zero_refresh(tick.now_ms, drive);
			end
		end
		endcase

		r.mode         = mode_now;
		r.drive_update = drive;
		r.servo_x_us   = drive ? pulse_us(lat_x, ofs_now[AXIS_X]) : '0;
		r.servo_y_us   = drive ? pulse_us(lat_y, ofs_now[AXIS_Y]) : '0;
		r.throttle_out = drive ? lat_thr[THR_W-1:0] : '0;
		r.offset_x     = ofs_now[AXIS_X][OFS_W-1:0];
		r.offset_y     = ofs_now[AXIS_Y][OFS_W-1:0];
		r.save_offsets = save;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t ns: mismatch on %s, expected %0d, actual %0d",
				$time, name, $signed(want), $signed(got));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		item_t   tick;
		if (!arst_n) begin
			clear_model();
			servo_results_due.delete();
			results_due <= 0;
		end else begin
			// result side first: a result can never belong to a tick of the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got.mode         = m_axis_tuser[1:0];
				got.drive_update = m_axis_tuser[2];
				got.servo_x_us   = m_axis_tdata[10:0];
				got.servo_y_us   = m_axis_tdata[21:11];
				got.throttle_out = m_axis_tdata[32:22];
				got.offset_x     = m_axis_tdata[41:33];
				got.offset_y     = m_axis_tdata[50:42];
				got.save_offsets = m_axis_tdata[51];
				if (servo_results_due.size() == 0) begin
					fails++;
					$display("%0t ns: result transfer with nothing expected, expected none, actual %h/%h",
						$time, m_axis_tuser, m_axis_tdata);
				end else begin
					want = servo_results_due.pop_front();
					compare_field("mode", want.mode, got.mode);
					compare_field("drive_update", want.drive_update, got.drive_update);
					compare_field("servo_x_us", want.servo_x_us, got.servo_x_us);
					compare_field("servo_y_us", want.servo_y_us, got.servo_y_us);
					compare_field("throttle_out", want.throttle_out, got.throttle_out);
					compare_field("offset_x", want.offset_x, got.offset_x);
					compare_field("offset_y", want.offset_y, got.offset_y);
					compare_field("save_offsets", want.save_offsets, got.save_offsets);
				end
			end
			if (psel && penable && pwrite && pready)
				apply_register(paddr[ADDR_W-1:2], pwdata);
			if (s_axis_tvalid && s_axis_tready) begin
				tick.packet_valid = s_axis_tuser;
				tick.stick_x      = s_axis_tdata[9:0];
				tick.stick_y      = s_axis_tdata[19:10];
				tick.throttle     = s_axis_tdata[30:20];
				tick.buttons      = s_axis_tdata[38:31];
				tick.now_ms       = s_axis_tdata[70:39];
				predict_servo_tick(tick, want);
				servo_results_due.push_back(want);
			end
			results_due <= servo_results_due.size();
		end
		mismatches <= fails;
	end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the servo link mode controller: directed ticks through every
// mode change but link loss in normal mode, and every button case, then random
// sessions of driving, calibration, link loss and noise under several register
// settings, with random gaps on both streams
// ----------------------------------------------------------------------------
module tb;
	import slmc_pkg::*;
	import slmc_tb_pkg::*;

	localparam int TICKS_PER_PHASE = 240;
	localparam int DRAIN_LIMIT     = 20000;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [71:0]         s_axis_tdata  = '0;
	logic                s_axis_tuser  = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [55:0]         m_axis_tdata;
	logic [2:0]          m_axis_tuser;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [ADDR_W-1:0]   paddr         = '0;
	logic [DATA_W-1:0]   pwdata        = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	int results_due;
	int mismatches;

	logic [31:0] clock_ms = '0;
	int          tb_tmo   = 500;
	int          tb_hold  = 5000;
	int          tb_refr  = 100;
	int          ticks_sent = 0;
	bit          tx_calm  = 1'b0;
	logic        squeeze_tog = 1'b0;

	servo_link_mode_controller_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	slmc_checker track (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.results_due   (results_due),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int rnd_stick();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return -512;
		if (r == 1) return 511;
		return int'($urandom_range(0, 1023)) - 512;
	endfunction

	function automatic int rnd_thrust();
		int m;
		m = int'($urandom_range(1, 1023));
		return $urandom_range(0, 1) ? m : -m;
	endfunction

	function automatic logic [7:0] pick_buttons();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 8'h00;
		if (r < 88) return 8'b1 << $urandom_range(BTN_Y_UP, BTN_X_UP);
		return 8'($urandom_range(0, 255));
	endfunction

	// one tick transfer on the input stream, with an optional gap before it
	task automatic offer_tick(bit pkt, int sx, int sy, int thr, logic [7:0] btn,
			int unsigned dt);
		int unsigned gap;
		gap = tx_calm ? 0 : pick_gap();
		clock_ms = clock_ms + dt;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= pkt;
		s_axis_tdata  <= {1'b0, clock_ms, btn, thr[10:0], sy[9:0], sx[9:0]};
		do @(posedge clk); while (!s_axis_tready);
		ticks_sent++;
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		int n;
		s_axis_tvalid <= 1'b0;
		n = 0;
		do begin
			@(posedge clk);
			n++;
		end while ((results_due != 0 || n < 4) && n < DRAIN_LIMIT);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
		REG_LINK_TMO: tb_tmo = int'(val[15:0]);
		REG_ZERO_HOLD: tb_hold = int'(val[15:0]);
		REG_REFRESH: tb_refr = int'(val[15:0]);
		default: ;
		endcase
	endtask

	task automatic set_phase(int ox, int oy, int tmo, int hold, int refr);
		drain();
		reg_write(REG_OFS_X_START, ox);
		reg_write(REG_OFS_Y_START, oy);
		reg_write(REG_LINK_TMO, tmo);
		reg_write(REG_ZERO_HOLD, hold);
		reg_write(REG_REFRESH, refr);
	endtask

	// zero-throttle packets; from normal mode the hold time has to run out first
	task automatic calib_session();
		int n;
		n = $urandom_range(3, 14);
		repeat (n) begin
			offer_tick(1'b1, rnd_stick(), rnd_stick(), 0, pick_buttons(),
				$urandom_range(0, 1) ? $urandom_range(0, 3) : tb_hold / 2 + 1);
		end
		if ($urandom_range(0, 3) != 0)
			offer_tick(1'b1, rnd_stick(), rnd_stick(), rnd_thrust(), pick_buttons(),
				$urandom_range(0, 4));
	endtask

	task automatic drive_run();
		int n;
		n = $urandom_range(4, 16);
		repeat (n) begin
			offer_tick(1'b1, rnd_stick(), rnd_stick(),
				($urandom_range(0, 6) == 0) ? 0 : rnd_thrust(), pick_buttons(),
				$urandom_range(0, tb_tmo / 2 + 1));
		end
	endtask

	task automatic link_loss();
		int n;
		n = $urandom_range(0, 3);
		repeat (n) offer_tick(1'b0, rnd_stick(), rnd_stick(), rnd_thrust(), 8'h00,
			$urandom_range(0, 4));
		offer_tick(1'b0, rnd_stick(), rnd_stick(), 0, pick_buttons(),
			tb_tmo + 1 + $urandom_range(0, 3));
		n = $urandom_range(2, 8);
		repeat (n) offer_tick(1'b0, rnd_stick(), rnd_stick(), rnd_thrust(), 8'h00,
			$urandom_range(0, tb_refr + 2));
		if ($urandom_range(0, 1))
			offer_tick(1'b1, rnd_stick(), rnd_stick(), rnd_thrust(), pick_buttons(),
				$urandom_range(0, tb_refr + 2));
	endtask

	task automatic noise();
		int n;
		int unsigned dt;
		n = $urandom_range(2, 8);
		repeat (n) begin
			dt = ($urandom_range(0, 4) == 0) ? $urandom() - clock_ms : $urandom_range(0, 40);
			offer_tick(1'(($urandom_range(0, 1))), int'($urandom_range(0, 1023)) - 512,
				int'($urandom_range(0, 1023)) - 512,
				($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 2046)) - 1023,
				8'($urandom_range(0, 255)), dt);
		end
	endtask

	task automatic random_sessions(bit squeeze);
		int unsigned pick;
		int          start;
		start = ticks_sent;
		while (ticks_sent - start < TICKS_PER_PHASE) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			if (squeeze && ticks_sent - start > TICKS_PER_PHASE / 2) begin
				// receiver holds off while the sender keeps offering
				squeeze = 1'b0;
				squeeze_tog <= ~squeeze_tog;
				tx_calm = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 32) calib_session();
			else if (pick < 62) drive_run();
			else if (pick < 80) link_loss();
			else if (pick < 97) noise();
			else drain();
		end
		tx_calm = 1'b0;
	endtask

	// receiving side: random stalls, calm stretches and the occasional long hold
	initial begin : rx_side
		int  stall;
		int  steady_left;
		bit  steady;
		logic seen_tog;
		stall       = 0;
		steady_left = 0;
		steady      = 1'b0;
		seen_tog    = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_tog != seen_tog) begin
				seen_tog = squeeze_tog;
				stall    = 150;
			end
			if (steady_left == 0) begin
				steady      = ($urandom_range(0, 3) == 0);
				steady_left = $urandom_range(20, 200);
			end else begin
				steady_left--;
			end
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else if (!steady && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				stall = pick_gap();
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] y_up;
		logic [7:0] y_dn;
		logic [7:0] x_dn;
		logic [7:0] x_up;
		y_up = 8'b1 << BTN_Y_UP;
		y_dn = 8'b1 << BTN_Y_DOWN;
		x_dn = 8'b1 << BTN_X_DOWN;
		x_up = 8'b1 << BTN_X_UP;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: offsets at the limits so the pulses clamp, short timers
		set_phase(-160, 160, 30, 20, 10);
		tx_calm = 1'b1;
		offer_tick(1'b0, 0, 0, 0, 8'h00, 0);
		offer_tick(1'b1, -512, 511, 700, 8'h00, 1);
		offer_tick(1'b1, -512, 511, 0, y_up, 1);
		offer_tick(1'b1, 0, 0, 0, 8'h00, 1);
		offer_tick(1'b1, 511, -512, 0, 8'h00, 1);
		offer_tick(1'b1, 511, -512, 0, y_dn, 1);
		offer_tick(1'b1, 100, -100, 0, 8'h00, 1);
		// press right after a release is a glitch
		offer_tick(1'b1, 100, -100, 0, y_dn, 1);
		offer_tick(1'b1, 0, 0, 0, 8'h00, 1);
		offer_tick(1'b1, 0, 0, 0, 8'h00, 1);
		// all four at once: Y up wins
		offer_tick(1'b1, 0, 0, 0, 8'h0f, 1);
		offer_tick(1'b1, 0, 0, 0, 8'h00, 1);
		offer_tick(1'b1, 0, 0, 0, 8'h00, 1);
		offer_tick(1'b1, -512, 0, 0, x_dn, 1);
		offer_tick(1'b1, 0, 0, 0, 8'h00, 1);
		offer_tick(1'b1, 0, 0, 0, 8'h00, 1);
		offer_tick(1'b1, 0, 511, 0, x_up, 1);
		offer_tick(1'b1, 0, 0, 0, 8'hf0, 1);
		// leave calibration with changed offsets
		offer_tick(1'b1, 511, -512, 1023, 8'h00, 1);
		offer_tick(1'b1, 511, -512, -1023, 8'h00, 5);
		offer_tick(1'b1, 3, -7, 0, 8'h00, 5);
		offer_tick(1'b1, 3, -7, 0, x_up, 21);
		// link lost in calibration
		offer_tick(1'b0, 0, 0, 0, 8'h00, 31);
		offer_tick(1'b1, 0, 0, -1, 8'h00, 1);
		tx_calm = 1'b0;
		random_sessions(1'b0);

		set_phase(0, 0, 500, 5000, 100);
		random_sessions(1'b1);

		set_phase(160, -160, 0, 0, 0);
		random_sessions(1'b0);

		// an out-of-range start value loads both as zero; timers at their maximum
		set_phase(200, 37, 65535, 65535, 65535);
		clock_ms = 32'hffff_fe00;
		random_sessions(1'b1);

		set_phase(-256, 255, 1, 2, 3);
		random_sessions(1'b0);

		set_phase(int'($urandom_range(0, 320)) - 160, int'($urandom_range(0, 320)) - 160,
			$urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 300));
		random_sessions(1'b1);

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/core/slmc_pkg.sv
rtl/core/slmc_regs.sv
rtl/core/slmc_engine.sv
rtl/core/servo_link_mode_controller_top.sv
rtl/core/slmc_checker.sv
bench/slmc_tb_pkg.sv
bench/slmc_checker.sv
bench/tb.sv
